### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent checks on the clock and asynchronous reset of the block.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);
`endif

### rtl/ptd_pkg.sv
`timescale 1ns / 1ps
package ptd_pkg;
	localparam int MaxTasks = 8;
	localparam int SlotW = 3;
	localparam int CountW = 4;
	localparam logic [7:0] CatchupLimit = 8'd255;
	localparam logic [9:0] CostScale = 10'd1000;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0, OP_REGISTER = 3'd1, OP_ENABLE = 3'd2, OP_DISPATCH = 3'd3,
		OP_FINISH = 3'd4, OP_QUERY = 3'd5, OP_CLEAR = 3'd6, OP_NONE = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_SCAN, ST_STEP, ST_FIX, ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [2:0]  task_slot;
		logic [15:0] period;
		logic [15:0] offset;
		logic [7:0]  prio;
		logic        enable_flag;
		logic [31:0] cost_us;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  slot_out;
		logic [31:0] next_release;
		logic [31:0] runs;
		logic [31:0] overruns;
		logic [31:0] max_cost;
		logic [31:0] last_cost;
	} rsp_t;

	typedef struct packed {
		logic [31:0] release_t;
		logic [15:0] period;
		logic [7:0]  prio;
		logic        enabled;
	} entry_t;

	function automatic logic reached(input logic [31:0] now, input logic [31:0] tgt);
		logic [31:0] d;
		d = now - tgt;
		return ~d[31];
	endfunction

	function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return (d != 32'd0) && !d[31];
	endfunction
endpackage

### rtl/ptd_scan.sv
`timescale 1ns / 1ps
module ptd_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          step,
	input  logic [ptd_pkg::SlotW-1:0]     idx,
	input  logic [ptd_pkg::CountW-1:0]    total,
	input  logic [31:0]                   now,
	input  ptd_pkg::entry_t               ent,
	output logic                          found,
	output logic [ptd_pkg::SlotW-1:0]     sel
);
	logic [7:0]  best_prio_q;
	logic [31:0] best_rel_q;
	logic        take;

	always_comb begin
		take = ({1'b0, idx} < total) && ent.enabled && (ent.period != 16'd0) &&
			ptd_pkg::reached(now, ent.release_t) &&
			(!found || ent.prio < best_prio_q ||
			(ent.prio == best_prio_q && ptd_pkg::earlier(ent.release_t, best_rel_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
			sel <= '0;
		end else if (start) begin
			found <= 1'b0;
			sel <= '0;
		end else if (step && take) begin
			found <= 1'b1;
			sel <= idx;
		end
	end

	always_ff @(posedge clk) begin
		if (step && take) begin
			best_prio_q <= ent.prio;
			best_rel_q <= ent.release_t;
		end
	end
endmodule

### rtl/periodic_task_dispatcher.sv
`timescale 1ns / 1ps
// Sequence: each accepted request is executed and its result then held for output, except
// for dispatch, which runs setup, eight slot scans and one decision when no task is
// due, and then one catch-up step per period (1 to 255) and a fix when one is chosen.
// Throughput: one request at a time; ready again the cycle after the result is taken.
// The slot scan compares in ptd_scan; the catch-up loop has its own 32-bit adder and comparator.
// Reset clears the task tables (priorities go to 8'hff), the tick counter and the task count at once.
`include "assert_macros.svh"
module periodic_task_dispatcher (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ptd_pkg::req_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ptd_pkg::rsp_t   out_data
);
	localparam int N = ptd_pkg::MaxTasks;
	localparam int SW = ptd_pkg::SlotW;

	ptd_pkg::state_t state_q, state_d;
	ptd_pkg::req_t   req_q;
	ptd_pkg::rsp_t   rsp_q;
	ptd_pkg::rsp_t   exec_rsp;
	logic [31:0] tick_q;
	logic [ptd_pkg::CountW-1:0] total_q;
	logic [15:0] period_q [N];
	logic [15:0] offset_q [N];
	logic [7:0]  prio_q [N];
	logic        en_q [N];
	logic [31:0] rel_q [N];
	logic [31:0] run_q [N];
	logic [31:0] ovr_q [N];
	logic [31:0] maxc_q [N];
	logic [31:0] lastc_q [N];
	logic [SW-1:0] idx_q;
	logic [7:0]    steps_q;
	logic          found;
	logic [SW-1:0] sel;
	ptd_pkg::entry_t ent;
	logic [SW-1:0] cs;
	logic [31:0] new_rel;
	logic        slot_ok;
	logic        scan_start, scan_step;
	logic [25:0] lim;

	assign slot_ok = {1'b0, req_q.task_slot} < total_q;
	assign cs = (state_q == ptd_pkg::ST_SCAN) ? idx_q : sel;
	assign ent = '{release_t: rel_q[idx_q], period: period_q[idx_q],
		prio: prio_q[idx_q], enabled: en_q[idx_q]};
	assign new_rel = rel_q[cs] + {16'd0, period_q[cs]};
	assign lim = period_q[req_q.task_slot] * ptd_pkg::CostScale;
	assign in_ready = (state_q == ptd_pkg::ST_IDLE);
	assign out_valid = (state_q == ptd_pkg::ST_DONE);
	assign out_data = rsp_q;
	assign scan_start = (state_q == ptd_pkg::ST_EXEC);
	assign scan_step = (state_q == ptd_pkg::ST_SCAN);

	ptd_scan u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .step(scan_step),
		.idx(idx_q), .total(total_q), .now(tick_q), .ent(ent),
		.found(found), .sel(sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptd_pkg::ST_IDLE: begin
				if (in_valid) state_d = ptd_pkg::ST_EXEC;
			end
			ptd_pkg::ST_EXEC: begin
				if (req_q.opcode == ptd_pkg::OP_DISPATCH) state_d = ptd_pkg::ST_SCAN;
				else state_d = ptd_pkg::ST_DONE;
			end
			ptd_pkg::ST_SCAN: begin
				if (idx_q == SW'(N - 1)) state_d = ptd_pkg::ST_STEP;
			end
			ptd_pkg::ST_STEP: begin
				if (!found) state_d = ptd_pkg::ST_DONE;
				else if (!ptd_pkg::reached(tick_q, new_rel) ||
					steps_q + 8'd1 >= ptd_pkg::CatchupLimit) state_d = ptd_pkg::ST_FIX;
			end
			ptd_pkg::ST_FIX: state_d = ptd_pkg::ST_DONE;
			ptd_pkg::ST_DONE: begin
				if (out_ready) state_d = ptd_pkg::ST_IDLE;
			end
			default: state_d = ptd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		exec_rsp = '0;
		unique case (ptd_pkg::opcode_t'(req_q.opcode))
			ptd_pkg::OP_TICK: exec_rsp.ok = 1'b1;
			ptd_pkg::OP_REGISTER: begin
				if (req_q.period != 16'd0 && total_q < ptd_pkg::CountW'(N)) begin
					exec_rsp.ok = 1'b1;
					exec_rsp.slot_out = total_q[SW-1:0];
				end
			end
			ptd_pkg::OP_ENABLE, ptd_pkg::OP_FINISH, ptd_pkg::OP_CLEAR:
				exec_rsp.ok = slot_ok;
			ptd_pkg::OP_QUERY: begin
				if (slot_ok) begin
					exec_rsp.ok = 1'b1;
					exec_rsp.next_release = rel_q[req_q.task_slot];
					exec_rsp.runs = run_q[req_q.task_slot];
					exec_rsp.overruns = ovr_q[req_q.task_slot];
					exec_rsp.max_cost = maxc_q[req_q.task_slot];
					exec_rsp.last_cost = lastc_q[req_q.task_slot];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			total_q <= '0;
			idx_q <= '0;
			steps_q <= '0;
			for (int i = 0; i < N; i++) begin
				period_q[i] <= '0;
				offset_q[i] <= '0;
				prio_q[i] <= 8'hff;
				en_q[i] <= 1'b0;
				rel_q[i] <= '0;
				run_q[i] <= '0;
				ovr_q[i] <= '0;
				maxc_q[i] <= '0;
				lastc_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ptd_pkg::ST_EXEC: begin
					idx_q <= '0;
					steps_q <= '0;
					unique case (ptd_pkg::opcode_t'(req_q.opcode))
						ptd_pkg::OP_TICK: tick_q <= tick_q + 32'd1;
						ptd_pkg::OP_REGISTER: begin
							if (req_q.period != 16'd0 && total_q < ptd_pkg::CountW'(N)) begin
								period_q[total_q[SW-1:0]] <= req_q.period;
								offset_q[total_q[SW-1:0]] <= req_q.offset;
								prio_q[total_q[SW-1:0]] <= req_q.prio;
								en_q[total_q[SW-1:0]] <= 1'b1;
								rel_q[total_q[SW-1:0]] <= tick_q + {16'd0, req_q.offset};
								run_q[total_q[SW-1:0]] <= '0;
								ovr_q[total_q[SW-1:0]] <= '0;
								maxc_q[total_q[SW-1:0]] <= '0;
								lastc_q[total_q[SW-1:0]] <= '0;
								total_q <= total_q + ptd_pkg::CountW'(1);
							end
						end
						ptd_pkg::OP_ENABLE: begin
							if (slot_ok) begin
								en_q[req_q.task_slot] <= req_q.enable_flag;
								if (req_q.enable_flag)
									rel_q[req_q.task_slot] <= tick_q +
										{16'd0, offset_q[req_q.task_slot]};
							end
						end
						ptd_pkg::OP_FINISH: begin
							if (slot_ok) begin
								lastc_q[req_q.task_slot] <= req_q.cost_us;
								if (req_q.cost_us > maxc_q[req_q.task_slot])
									maxc_q[req_q.task_slot] <= req_q.cost_us;
								if (req_q.cost_us >= {6'd0, lim})
									ovr_q[req_q.task_slot] <= ovr_q[req_q.task_slot] + 32'd1;
								run_q[req_q.task_slot] <= run_q[req_q.task_slot] + 32'd1;
							end
						end
						ptd_pkg::OP_CLEAR: begin
							if (slot_ok) maxc_q[req_q.task_slot] <= '0;
						end
						default: ;
					endcase
				end
				ptd_pkg::ST_SCAN: idx_q <= idx_q + SW'(1);
				ptd_pkg::ST_STEP: begin
					if (found) begin
						rel_q[cs] <= new_rel;
						steps_q <= steps_q + 8'd1;
					end
				end
				ptd_pkg::ST_FIX: begin
					if (ptd_pkg::reached(tick_q, rel_q[cs])) begin
						rel_q[cs] <= tick_q + {16'd0, period_q[cs]};
						ovr_q[cs] <= ovr_q[cs] + {24'd0, steps_q};
					end else begin
						ovr_q[cs] <= ovr_q[cs] + {24'd0, steps_q} - 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptd_pkg::ST_IDLE && in_valid) req_q <= in_data;
		if (state_q == ptd_pkg::ST_EXEC) rsp_q <= exec_rsp;
		if (state_q == ptd_pkg::ST_STEP && found) begin
			rsp_q.ok <= 1'b1;
			rsp_q.slot_out <= sel;
		end
	end

	`ASSERT_CLK(a_ready_idle, !(in_ready && out_valid), "ready while result pending")
	`ASSERT_NEXT(a_total_max, 1'b1, total_q <= ptd_pkg::CountW'(N), "task count overflow")
	`ASSERT_NEXT(a_done_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
	`ASSERT_NEXT(a_steps_lim, state_q == ptd_pkg::ST_STEP, steps_q <= ptd_pkg::CatchupLimit, "catch-up exceeded limit")
endmodule
